// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the sigmoid activation unit.
// No dependencies; included by files that carry concurrent assertions.
// Each macro expands to one labelled clocked assertion reset by an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sau_pkg.sv -----
// Package of the sigmoid activation unit: sample types, fixed widths and the
// elaboration-time functions that build the sigmoid sample table.
// No dependencies; used by sau_sample_rom and sigmoid_activation_unit.
package sau_pkg;

    localparam int SAMP_W     = 16;
    localparam int S24_W      = 25;
    localparam int NUM_STAGES = 8;

    localparam logic [63:0] Q_ONE = 64'h1000_0000_0000_0000;

    typedef logic [SAMP_W-1:0] t_samp;

    typedef struct packed {
        t_samp lo_val;
        t_samp hi_val;
    } t_samp_pair;

    // Bits 123 to 60 of the full product, i.e. a Q60 multiply.
    function automatic logic [63:0] q_mulq(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] pr;
        pr = {64'd0, a} * {64'd0, b};
        return pr[123:60];
    endfunction

    // Restoring long division, used only while the table is elaborated.
    function automatic logic [63:0] q_udiv(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] rm;
        logic [63:0] qt;
        rm = '0;
        qt = '0;
        for (int i = 63; i >= 0; i--) begin
            rm = {rm[63:0], a[i]};
            if (rm >= {1'b0, b}) begin
                rm    = rm - {1'b0, b};
                qt[i] = 1'b1;
            end
        end
        return qt;
    endfunction

    // exp(-8/segs) in Q60 from a 40-term series.
    function automatic logic [63:0] q_series_base(input int segs);
        logic [63:0] step;
        logic [63:0] term;
        logic [63:0] base;
        step = q_udiv(64'h8000_0000_0000_0000, 64'(segs));
        term = Q_ONE;
        base = Q_ONE;
        for (int n = 1; n <= 40; n++) begin
            term = q_udiv(q_mulq(term, step), 64'(n));
            if ((n % 2) == 1) begin
                base = base - term;
            end else begin
                base = base + term;
            end
        end
        return base;
    endfunction

    // Sample k of the sigmoid in Q0.16, rounded half up.
    function automatic t_samp q_sample(input int k, input logic [63:0] base);
        logic [63:0] e;
        logic [63:0] d40;
        logic [63:0] qt;
        e = Q_ONE;
        for (int j = 0; j < k; j++) begin
            e = q_mulq(e, base);
        end
        d40 = (Q_ONE + e) >> 20;
        qt  = q_udiv(64'h0100_0000_0000_0000 + (d40 >> 1), d40);
        return qt[SAMP_W-1:0];
    endfunction

endpackage

// ----- hdl/sau_sample_rom.sv -----
// Constant sigmoid sample table with two combinational read ports.
// Depends on sau_pkg for the sample types and the table-building functions.
// Returns the sample at the index and the one after it, clamped at the end.
module sau_sample_rom #(
    parameter int SEGS = 256
) (
    input  logic [$clog2(SEGS+1)-1:0] i_idx,
    output sau_pkg::t_samp_pair       o_samp
);
    import sau_pkg::*;

    localparam int IW = $clog2(SEGS + 1);
    localparam logic [63:0] BASE = q_series_base(SEGS);

    t_samp         w_tab [0:SEGS];
    logic [IW-1:0] w_idx_hi;

    for (genvar g = 0; g <= SEGS; g++) begin : g_tab
        localparam t_samp SAMP_V = q_sample(g, BASE);
        assign w_tab[g] = SAMP_V;
    end

    assign w_idx_hi      = (i_idx == IW'(SEGS)) ? i_idx : i_idx + IW'(1);
    assign o_samp.lo_val = w_tab[i_idx];
    assign o_samp.hi_val = w_tab[w_idx_hi];

endmodule

// ----- hdl/sigmoid_activation_unit.sv -----
// Sigmoid activation unit, forward value and backward gradient, in an eight-stage pipeline.
// Depends on sau_pkg, sau_sample_rom and the assertion macros in assert_macros.svh.
// One word per clock in and out while the output is not stalled.
//
// Each input word carries a selector, x and a loss in signed fixed point. Forward words
// return sigmoid(x); backward words return loss*s*(1-s), saturated to the data width
// with the flag set when clipped. The sigmoid is interpolated linearly between the
// TABLE_SEGMENTS+1 entries of a constant sample table covering 0 to 8; larger |x| uses
// the last entry and negative x uses 1-s(-x). The pipeline takes a new word every cycle
// while the output is not stalled. Its stages are the index calculation, the table read,
// the interpolation, s*(1-s) and loss multiplies, each rounded in a stage of its own.
// Every stage stalls only when it holds a word that the next stage cannot take, so
// empty stages are filled while a finished result waits at the output.
module sigmoid_activation_unit #(
    parameter int DATA_WIDTH     = 16,
    parameter int FRAC_BITS      = 12,
    parameter int TABLE_SEGMENTS = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // x_value, loss_value, zero padding
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // req_type
    input  logic [0:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // result_value, zero padding
    output logic [((DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
    // saturated
    output logic [0:0]                           m_axis_tuser
);
    import sau_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int DSH   = F + 3;
    localparam int IW    = $clog2(TABLE_SEGMENTS + 1);
    localparam int PW    = DW + IW + DSH;
    localparam int SXW   = SAMP_W + DSH + 2;
    localparam int XW    = SXW + 2;
    localparam int WS    = SAMP_W + DSH;
    localparam int RSH   = (WS >= 24) ? WS - 24 : 0;
    localparam int LSH   = (WS >= 24) ? 0 : 24 - WS;
    localparam int FR    = 24 - F;
    localparam int RW    = ((DW > F) ? DW : F) + 2;
    localparam int PPW   = 2 * S24_W;
    localparam int PRW   = DW + S24_W;
    localparam int OTW   = ((DW + 7) / 8) * 8;

    localparam logic signed [RW-1:0] HI_V = (RW'(1) <<< (DW - 1)) - RW'(1);
    localparam logic signed [RW-1:0] LO_V = -HI_V - RW'(1);

    logic [NUM_STAGES:1]   r_vld;
    logic [NUM_STAGES+1:1] w_en;

    logic [DW-1:0]       w_xu;
    logic [DW-1:0]       w_lu;
    logic [DW-1:0]       w_mag;
    logic [PW-1:0]       w_pos;
    logic [DW+IW-1:0]    w_idx_full;
    logic                w_clamp;
    t_samp_pair          w_samp;
    logic signed [SXW-1:0] w_s;
    logic [SXW-1:0]      w_su;
    logic [XW-1:0]       w_x2;
    logic [S24_W:0]      w_f2;
    logic [PRW-1:0]      w_m;
    logic signed [RW-1:0] w_bv;
    logic signed [RW-1:0] w_val;

    logic                r_req1, r_req2, r_req3, r_req4, r_req5, r_req6, r_req7;
    logic                r_lneg1, r_lneg2, r_lneg3, r_lneg4, r_lneg5, r_lneg6, r_lneg7;
    logic [DW-1:0]       r_lm1, r_lm2, r_lm3, r_lm4, r_lm5, r_lm6;
    logic                r_neg1, r_neg2, r_neg3;
    logic [IW-1:0]       r_idx1;
    logic [DSH-1:0]      r_rem1, r_rem2;
    t_samp               r_t0_2;
    logic signed [SAMP_W:0] r_diff2;
    logic signed [SXW-1:0] r_s3;
    logic [S24_W-1:0]    r_s24_4;
    logic [RW-1:0]       r_fwd5, r_fwd6, r_fwd7;
    logic [PPW-1:0]      r_pp5;
    logic [S24_W-1:0]    r_p6;
    logic [PRW-1:0]      r_prod7;
    logic [DW-1:0]       r_res8;
    logic                r_sat8;

    always_comb begin
        w_en[NUM_STAGES+1] = m_axis_tready;
        for (int k = NUM_STAGES; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign s_axis_tready = w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign w_xu       = s_axis_tdata[DW-1:0];
    assign w_lu       = s_axis_tdata[2*DW-1:DW];
    assign w_mag      = w_xu[DW-1] ? (~w_xu + DW'(1)) : w_xu;
    assign w_pos      = PW'(w_mag) * PW'(TABLE_SEGMENTS);
    assign w_idx_full = w_pos[PW-1:DSH];
    assign w_clamp    = (w_idx_full >= (DW+IW)'(TABLE_SEGMENTS));

    sau_sample_rom #(
        .SEGS (TABLE_SEGMENTS)
    ) u_rom (
        .i_idx  (r_idx1),
        .o_samp (w_samp)
    );

    assign w_s  = $signed(SXW'({r_t0_2, {DSH{1'b0}}}))
                + SXW'(r_diff2) * $signed(SXW'(r_rem2));
    assign w_su = r_neg3 ? ((SXW'(1) << WS) - SXW'(r_s3)) : SXW'(r_s3);
    assign w_x2 = (XW'(w_su) << (LSH + 1)) >> RSH;
    assign w_f2 = ((S24_W+1)'(r_s24_4) << 1) >> FR;
    assign w_m  = (r_prod7 + (PRW'(1) << 23)) >> 24;
    assign w_bv = r_lneg7 ? -$signed(RW'(w_m)) : $signed(RW'(w_m));
    assign w_val = r_req7 ? w_bv : $signed(r_fwd7);

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_req1  <= s_axis_tuser[0];
            r_lneg1 <= w_lu[DW-1];
            r_lm1   <= w_lu[DW-1] ? (~w_lu + DW'(1)) : w_lu;
            r_neg1  <= w_xu[DW-1];
            r_idx1  <= w_clamp ? IW'(TABLE_SEGMENTS) : w_idx_full[IW-1:0];
            r_rem1  <= w_clamp ? '0 : w_pos[DSH-1:0];
        end
        if (w_en[2]) begin
            r_req2  <= r_req1;
            r_lneg2 <= r_lneg1;
            r_lm2   <= r_lm1;
            r_neg2  <= r_neg1;
            r_rem2  <= r_rem1;
            r_t0_2  <= w_samp.lo_val;
            r_diff2 <= $signed({1'b0, w_samp.hi_val}) - $signed({1'b0, w_samp.lo_val});
        end
        if (w_en[3]) begin
            r_req3  <= r_req2;
            r_lneg3 <= r_lneg2;
            r_lm3   <= r_lm2;
            r_neg3  <= r_neg2;
            r_s3    <= w_s;
        end
        if (w_en[4]) begin
            r_req4  <= r_req3;
            r_lneg4 <= r_lneg3;
            r_lm4   <= r_lm3;
            r_s24_4 <= S24_W'((w_x2 + XW'(1)) >> 1);
        end
        if (w_en[5]) begin
            r_req5  <= r_req4;
            r_lneg5 <= r_lneg4;
            r_lm5   <= r_lm4;
            r_fwd5  <= RW'((w_f2 + (S24_W+1)'(1)) >> 1);
            r_pp5   <= PPW'(r_s24_4) * PPW'((S24_W'(1) << 24) - r_s24_4);
        end
        if (w_en[6]) begin
            r_req6  <= r_req5;
            r_lneg6 <= r_lneg5;
            r_lm6   <= r_lm5;
            r_fwd6  <= r_fwd5;
            r_p6    <= S24_W'((r_pp5 + (PPW'(1) << 23)) >> 24);
        end
        if (w_en[7]) begin
            r_req7  <= r_req6;
            r_lneg7 <= r_lneg6;
            r_fwd7  <= r_fwd6;
            r_prod7 <= PRW'(r_lm6) * PRW'(r_p6);
        end
        if (w_en[8]) begin
            if (w_val > HI_V) begin
                r_res8 <= HI_V[DW-1:0];
                r_sat8 <= 1'b1;
            end else if (w_val < LO_V) begin
                r_res8 <= LO_V[DW-1:0];
                r_sat8 <= 1'b1;
            end else begin
                r_res8 <= w_val[DW-1:0];
                r_sat8 <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid   = r_vld[NUM_STAGES];
    assign m_axis_tdata    = OTW'(r_res8);
    assign m_axis_tuser[0] = r_sat8;

`include "assert_macros.svh"

    `SAU_ASSERT_SAME(a_stall_only_full, i_clk, i_rst_n, !s_axis_tready, &r_vld,
        "Input stalled while the pipeline has an empty stage.")
    `SAU_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready,
        r_vld[1], "Accepted word did not enter the first stage.")
    `SAU_ASSERT_NEXT(a_no_word_lost, i_clk, i_rst_n, 1'b1,
        ($countones(r_vld) + 1) >= $past($countones(r_vld)),
        "More than one word left the pipeline in a single cycle.")

endmodule

// ----- test/tb_sigmoid_activation_unit.sv -----
// Self-checking testbench for sigmoid_activation_unit: forward sigmoid and backward gradient words.
// Depends only on the unit under test; it builds its own sample table and predicts every result.
// Directed corner words come first, then random words with bursts of idling on both stream sides.
module tb_sigmoid_activation_unit;

    localparam int DATA_W       = 16;
    localparam int FRAC_W       = 12;
    localparam int SEGS         = 256;
    localparam int DEN_SH       = FRAC_W + 3;
    localparam longint DEN      = longint'(1) << DEN_SH;
    localparam int S24_SH       = FRAC_W + 19 - 24;
    localparam int WATCHDOG_MAX = 2000;
    localparam int DRAIN_CYCLES = 24;

    localparam logic [63:0] Q60_ONE = 64'd1 << 60;

    localparam logic REQ_FORWARD  = 1'b0;
    localparam logic REQ_BACKWARD = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              sat;
    } result_t;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // x_value, loss_value
    logic [31:0] s_axis_tdata  = '0;
    // req_type
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // result_value
    logic [15:0] m_axis_tdata;
    // saturated
    logic [0:0]  m_axis_tuser;

    longint  logistic_samples [0:SEGS];
    result_t expected_results [$];
    result_t want_word;
    int      error_count   = 0;
    int      quiet_cycles  = 0;
    int      tx_idle_pct   = 0;
    int      rx_idle_pct   = 0;

    sigmoid_activation_unit #(
        .DATA_WIDTH    (DATA_W),
        .FRAC_BITS     (FRAC_W),
        .TABLE_SEGMENTS(SEGS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] full;
        full = 128'(a) * 128'(b);
        return 64'(full >> 60);
    endfunction

    // The samples are sigmoid(k/32) in Q0.16, from exp(-k/32) as powers of a series value.
    initial begin : build_samples
        logic [63:0] step;
        logic [63:0] term;
        logic [63:0] base;
        logic [63:0] e;
        logic [63:0] d40;
        step = 64'h8000_0000_0000_0000 / 64'(SEGS);
        term = Q60_ONE;
        base = Q60_ONE;
        e    = Q60_ONE;
        for (int n = 1; n <= 40; n++) begin
            term = q60_product(term, step) / 64'(n);
            if ((n % 2) == 1) begin
                base = base - term;
            end else begin
                base = base + term;
            end
        end
        for (int k = 0; k <= SEGS; k++) begin
            d40 = (Q60_ONE + e) >> 20;
            logistic_samples[k] = longint'(((64'd1 << 56) + (d40 >> 1)) / d40);
            e = q60_product(e, base);
        end
    end

    function automatic result_t predict_word(input logic req, input logic signed [15:0] x,
                                             input logic signed [15:0] loss);
        longint  mag;
        longint  pos;
        longint  idx;
        longint  rem;
        longint  s;
        longint  s24;
        longint  p;
        longint  lm;
        longint  m;
        longint  r;
        result_t res;
        mag = (x < 0) ? -longint'(x) : longint'(x);
        pos = mag * SEGS;
        idx = pos >> DEN_SH;
        rem = pos & (DEN - 1);
        if (idx >= SEGS) begin
            s = logistic_samples[SEGS] * DEN;
        end else begin
            s = logistic_samples[idx] * DEN
                + (logistic_samples[idx+1] - logistic_samples[idx]) * rem;
        end
        if (x < 0) begin
            s = 65536 * DEN - s;
        end
        if (s < 0) begin
            s = 0;
        end
        s24 = (s + (longint'(1) << (S24_SH - 1))) >> S24_SH;
        if (req == REQ_FORWARD) begin
            r = (s24 + (longint'(1) << (23 - FRAC_W))) >> (24 - FRAC_W);
        end else begin
            p  = (s24 * ((longint'(1) << 24) - s24) + (longint'(1) << 23)) >> 24;
            lm = (loss < 0) ? -longint'(loss) : longint'(loss);
            m  = (lm * p + (longint'(1) << 23)) >> 24;
            r  = (loss < 0) ? -m : m;
        end
        res.sat = 1'b0;
        if (r > (longint'(1) << (DATA_W - 1)) - 1) begin
            r       = (longint'(1) << (DATA_W - 1)) - 1;
            res.sat = 1'b1;
        end else if (r < -(longint'(1) << (DATA_W - 1))) begin
            r       = -(longint'(1) << (DATA_W - 1));
            res.sat = 1'b1;
        end
        res.value = r[DATA_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(predict_word(s_axis_tuser[0], s_axis_tdata[15:0],
                                                        s_axis_tdata[31:16]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word value=%h sat=%b",
                             $time, m_axis_tdata, m_axis_tuser[0]);
                    error_count++;
                end else begin
                    want_word = expected_results.pop_front();
                    if (m_axis_tdata !== want_word.value) begin
                        $display("%0t: result_value expected %h actual %h",
                                 $time, want_word.value, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tuser[0] !== want_word.sat) begin
                        $display("%0t: saturated expected %b actual %b",
                                 $time, want_word.sat, m_axis_tuser[0]);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 99) < rx_idle_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_word(input logic req, input logic [15:0] x, input logic [15:0] loss);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {loss, x};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [15:0] random_x();
        int pick;
        int k;
        logic [15:0] v;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            v = 16'($urandom);
        end else if (pick < 6) begin
            v = 16'($urandom_range(0, 2047));
        end else if (pick < 8) begin
            k = $urandom_range(0, 255);
            v = 16'(k * 128 + $urandom_range(0, 2) - 1);
        end else begin
            v = 16'($urandom_range(32000, 32767));
        end
        if ($urandom_range(0, 1) == 1) begin
            v = -v;
        end
        return v;
    endfunction

    function automatic logic [15:0] random_loss();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick < 2) begin
            return 16'($urandom);
        end else if (pick == 2) begin
            return ($urandom_range(0, 1) == 1) ? 16'h7fff : 16'h8000;
        end
        return 16'($urandom_range(0, 31)) - 16'd16;
    endfunction

    task automatic test_forward_corners();
        logic [15:0] xs [13];
        xs = '{16'h0000, 16'h0001, 16'hffff, 16'h0080, 16'hff80, 16'h0081, 16'h1000,
               16'hf000, 16'h7fff, 16'h8000, 16'h7f80, 16'h8080, 16'h0010};
        foreach (xs[i]) begin
            send_word(REQ_FORWARD, xs[i], 16'($urandom));
        end
    endtask

    task automatic test_backward_corners();
        send_word(REQ_BACKWARD, 16'h0000, 16'h7fff);
        send_word(REQ_BACKWARD, 16'h0000, 16'h8000);
        send_word(REQ_BACKWARD, 16'h0000, 16'hffff);
        send_word(REQ_BACKWARD, 16'h0000, 16'h0001);
        send_word(REQ_BACKWARD, 16'h0000, 16'h0000);
        send_word(REQ_BACKWARD, 16'h7fff, 16'h7fff);
        send_word(REQ_BACKWARD, 16'h8000, 16'h8000);
        send_word(REQ_BACKWARD, 16'h1000, 16'h8000);
        send_word(REQ_BACKWARD, 16'hf000, 16'h7fff);
        send_word(REQ_BACKWARD, 16'h0001, 16'hffff);
        send_word(REQ_BACKWARD, 16'hf800, 16'h1000);
    endtask

    task automatic test_random_words(input int count);
        for (int i = 0; i < count; i++) begin
            send_word(logic'($urandom_range(0, 1)), random_x(), random_loss());
        end
    endtask

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 20;
        rx_idle_pct = 20;
        test_forward_corners();
        test_backward_corners();

        tx_idle_pct = 30;
        rx_idle_pct = 30;
        test_random_words(500);
        tx_idle_pct = 0;
        rx_idle_pct = 60;
        test_random_words(250);
        tx_idle_pct = 60;
        rx_idle_pct = 0;
        test_random_words(250);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_words(300);

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
